/* rtl/core/cif_pkg.sv */
// Package for the 3x3 image convolution filter: sizes, field widths and
// configuration register indexes. No dependencies.
`default_nettype none

package cif_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COEF_BITS  = 16;
  localparam int KSIZE      = 3;

  // Fixed widths of the port fields
  localparam int PIX_IN_W  = 8;
  localparam int DIM_W     = 11;
  localparam int MASK_W    = 48;
  localparam int SLOT_W    = 16;
  localparam int OUT_W     = 28;
  localparam int CFG_IDX_W = 3;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PROD_W = PIXEL_BITS + 1 + COEF_BITS;
  localparam int RSUM_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(KSIZE);
  localparam logic [DIM_W-1:0] W_MAX   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_MAX   = DIM_W'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_MASK_TOP     = 3'd2,
    REG_MASK_MIDDLE  = 3'd3,
    REG_MASK_BOTTOM  = 3'd4
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0]   pixel_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < DIM_MIN) res = DIM_MIN;
    else if (v > maxv) res = maxv;
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/conv3x3_image_filter.sv */
// Top level of the 3x3 image convolution filter: line store memory, window,
// multiply and adder-tree pipeline. Depends on cif_pkg.
//
// Usage
//   Pixels enter in raster order on the in_ channel, one beat per pixel; the
//   frame position is counted inside. A beat is taken at a rising edge with
//   in_valid high and in_stall low. For a frame of H rows by W columns the
//   block returns (H-2) x (W-2) results on the out_ channel, each the signed
//   sum of the 3x3 neighbourhood times the mask (kernel not flipped, mask
//   row 0 column 0 meets the top-left pixel). out_frame_last marks the final
//   result of a frame; after it the next pixel opens a new frame.
//   Config (width, height, 3 packed mask rows) is written on cfg_ by the user
//   only while no beat is in flight, not enforced; cfg_ready is always high.
// Timing
//   One pixel per clock sustained while no stall holds the pipeline. A result
//   is registered in turn at line store read, window shift, products, row sums
//   and final sum. The rate is set by the line store, which takes one read
//   and one write per pixel on separate ports: the read as the pixel is
//   accepted, the write back as the pixel leaves s1.
// Reset and stall
//   rst_n (synchronous) clears counters, pipeline valids and the registers
//   (width and height 1024, mask zero). Line store contents are undefined
//   until written and never reach a result within a well-formed frame.
//   out_stall holds the output register; the stall ripples back through
//   the pipeline and raises in_stall only once every stage is full.
`default_nettype none

module conv3x3_image_filter (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // pixel input
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [cif_pkg::PIX_IN_W-1:0]        in_pixel_value,
  // results
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [cif_pkg::OUT_W-1:0]    out_filtered_value,
  output logic                                out_frame_last,
  // configuration writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [cif_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [cif_pkg::MASK_W-1:0]          cfg_data
);
  import cif_pkg::*;

  // ---------------------------------------------------------------- config
  logic [DIM_W-1:0]  width_r, height_r;
  logic [MASK_W-1:0] mask_r [KSIZE];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= W_MAX;
      height_r <= H_MAX;
      for (int r = 0; r < KSIZE; r++) mask_r[r] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r  <= cfg_data[DIM_W-1:0];
        REG_MASK_TOP:     mask_r[0] <= cfg_data;
        REG_MASK_MIDDLE:  mask_r[1] <= cfg_data;
        REG_MASK_BOTTOM:  mask_r[2] <= cfg_data;
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  // Effective frame size, out-of-range values clamped
  logic [DIM_W-1:0] w_last, h_last;
  assign w_last = clamp_dim(width_r, W_MAX) - DIM_W'(1);
  assign h_last = clamp_dim(height_r, H_MAX) - DIM_W'(1);

  // Coefficients, low COEF_BITS of each 16-bit slot, two's complement
  logic signed [COEF_BITS-1:0] coef [KSIZE][KSIZE];
  always_comb begin
    for (int r = 0; r < KSIZE; r++)
      for (int k = 0; k < KSIZE; k++)
        coef[r][k] = $signed(mask_r[r][SLOT_W*k +: COEF_BITS]);
  end

  // ------------------------------------------------------- flow control
  // Stages: s1 line store data, s2 window, s3 products, s4 row sums, output.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic out_free, s4_free, s3_free, s2_free, s1_adv, acc;

  assign out_free = !out_vld_r || !out_stall;
  assign s4_free  = !s4_vld_r || out_free;
  assign s3_free  = !s3_vld_r || s4_free;
  assign s2_free  = !s2_vld_r || s3_free;
  assign s1_adv   = s1_vld_r && s2_free;
  assign in_stall = s1_vld_r && !s2_free;
  assign acc      = in_valid && !in_stall;

  // --------------------------------------------------- frame position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             at_last_col, at_last_row, acc_prod, acc_last;

  assign at_last_col = DIM_W'(col_r) >= w_last;
  assign at_last_row = DIM_W'(row_r) >= h_last;
  assign acc_prod    = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign acc_last    = at_last_col && at_last_row;

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (at_last_col) begin
      col_nxt = '0;
      row_nxt = at_last_row ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ------------------------------------------------------- line store
  // One entry per column: low half the previous row, high half the row
  // before that. Read at accept, written back as the pixel leaves s1.
  // Consecutive pixels never share a column, so no forwarding is needed.
  logic [2*PIXEL_BITS-1:0] lstore [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_data_r;
  logic [COL_W-1:0]        s1_addr_r;
  pixel_t                  s1_pix_r, up1, up2;
  logic                    s1_prod_r, s1_last_r;

  assign up1 = rd_data_r[PIXEL_BITS-1:0];
  assign up2 = rd_data_r[2*PIXEL_BITS-1:PIXEL_BITS];

  always_ff @(posedge clk) begin
    if (acc) rd_data_r <= lstore[col_r];
    if (s1_adv) lstore[s1_addr_r] <= {up1, s1_pix_r};
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r <= col_r;
      s1_pix_r  <= in_pixel_value[PIXEL_BITS-1:0];
      s1_prod_r <= acc_prod;
      s1_last_r <= acc_last;
    end
  end

  // ----------------------------------------------------------- window
  pixel_t win_r [KSIZE][KSIZE];
  logic   s2_last_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int r = 0; r < KSIZE; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= up1;
      win_r[2][2] <= s1_pix_r;
      s2_last_r   <= s1_last_r;
    end
  end

  // --------------------------------------------------------- products
  prod_t prod_r [KSIZE][KSIZE];
  logic  s3_last_r;

  always_ff @(posedge clk) begin
    if (s3_free && s2_vld_r) begin
      for (int r = 0; r < KSIZE; r++)
        for (int k = 0; k < KSIZE; k++)
          prod_r[r][k] <= PROD_W'($signed({1'b0, win_r[r][k]})) * PROD_W'(coef[r][k]);
      s3_last_r <= s2_last_r;
    end
  end

  // --------------------------------------------------------- row sums
  rsum_t rsum_r [KSIZE];
  logic  s4_last_r;

  always_ff @(posedge clk) begin
    if (s4_free && s3_vld_r) begin
      for (int r = 0; r < KSIZE; r++)
        rsum_r[r] <= RSUM_W'(prod_r[r][0]) + RSUM_W'(prod_r[r][1])
                   + RSUM_W'(prod_r[r][2]);
      s4_last_r <= s3_last_r;
    end
  end

  // ------------------------------------------------------ final sum
  logic signed [SUM_W-1:0] total;
  logic signed [OUT_W-1:0] out_value_r;
  logic                    out_last_r;

  assign total = SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);

  always_ff @(posedge clk) begin
    if (out_free && s4_vld_r) begin
      out_value_r <= OUT_W'(total);
      out_last_r  <= s4_last_r;
    end
  end

  // ------------------------------------------------------ stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!s1_vld_r || s1_adv) s1_vld_r <= acc;
      if (s2_free)  s2_vld_r  <= s1_adv && s1_prod_r;
      if (s3_free)  s3_vld_r  <= s2_vld_r;
      if (s4_free)  s4_vld_r  <= s3_vld_r;
      if (out_free) out_vld_r <= s4_vld_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_filtered_value = out_value_r;
  assign out_frame_last     = out_last_r;

  // ------------------------------------------------------- assertions
  // A write back and a fresh read never meet at one column
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && s1_adv) |-> (col_r != s1_addr_r))
    else $error("line store read and write hit the same column");

  // A new pixel enters s1 only when its occupant moves on
  a_s1_single: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (!s1_vld_r || s1_adv))
    else $error("pixel accepted over a held s1 entry");

  // The last pixel of a frame returns the position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && acc_last) |=> (col_r == '0 && row_r == '0))
    else $error("frame position not cleared after last pixel");

  // A result flagged last was produced by a pixel that was itself producing
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |-> s1_prod_r)
    else $error("frame end flagged on a non-producing pixel");

endmodule

`default_nettype wire

/* tb/tb_conv3x3_image_filter.sv */
// Self-checking testbench for conv3x3_image_filter: pixel frames in, filtered sums out.
// The scoreboard class predicts each window sum. Depends on cif_pkg and the filter RTL.
module tb_conv3x3_image_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import cif_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PIXELS = 900;
  localparam int REPORT_LIMIT  = 10;
  localparam int NUM_REGS      = 5;

  // Register indexes past the end of the map. The block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  localparam logic [SLOT_W-1:0] COEF_MIN = 16'h8000;
  localparam logic [SLOT_W-1:0] COEF_MAX = 16'h7FFF;

  typedef enum int {PIX_RANDOM, PIX_FULL, PIX_CHECKER, PIX_RAILS, PIX_DIM} pixel_style_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
  } window_sum_t;

  // Keeps a shadow copy of the filter state: the registers, both line stores,
  // the 3x3 window and the raster counters. It computes the sum expected for
  // every window-completing pixel beat and checks each result beat in arrival order.
  class conv_window_checker;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [MASK_W-1:0]     mask_rows [KSIZE];
    logic [PIXEL_BITS-1:0] line_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] line_b [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] win [KSIZE][KSIZE];
    int unsigned           col_cnt;
    int unsigned           row_cnt;
    window_sum_t           pending_sums [$];
    int                    fail_count;

    function new();
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      foreach (mask_rows[r]) mask_rows[r] = '0;
      foreach (line_a[i]) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      foreach (win[r, k]) win[r][k] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      fail_count = 0;
    endfunction

    // Out-of-range sizes act as the nearest legal one
    function int unsigned eff_width();
      if (width_reg < KSIZE) return KSIZE;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < KSIZE) return KSIZE;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg    = data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_reg   = data[DIM_W-1:0];
        REG_MASK_TOP:     mask_rows[0] = data;
        REG_MASK_MIDDLE:  mask_rows[1] = data;
        REG_MASK_BOTTOM:  mask_rows[2] = data;
        default: ;
      endcase
    endfunction

    function void take_pixel(logic [PIXEL_BITS-1:0] pix);
      int unsigned           w;
      int unsigned           h;
      int unsigned           c;
      logic [PIXEL_BITS-1:0] up1;
      logic [PIXEL_BITS-1:0] up2;
      longint                acc;
      shortint               coef;
      window_sum_t           res;
      w   = eff_width();
      h   = eff_height();
      c   = col_cnt % MAX_WIDTH;
      up1 = line_a[c];
      up2 = line_b[c];
      for (int r = 0; r < KSIZE; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = pix;
      line_b[c] = up1;
      line_a[c] = pix;
      if (row_cnt >= 2 && col_cnt >= 2) begin
        acc = 0;
        // not flipped: mask row 0, column 0 meets the top-left (oldest) pixel
        for (int r = 0; r < KSIZE; r++) begin
          for (int k = 0; k < KSIZE; k++) begin
            coef = mask_rows[r][SLOT_W*k +: SLOT_W];
            acc += longint'(coef) * longint'(win[r][k]);
          end
        end
        res.value = acc[OUT_W-1:0];
        res.last  = (row_cnt >= h - 1) && (col_cnt >= w - 1);
        pending_sums.push_back(res);
      end
      if (col_cnt >= w - 1) begin
        col_cnt = 0;
        row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
    endfunction

    function void check_sum(logic [OUT_W-1:0] got_val, logic got_last);
      window_sum_t want;
      if (pending_sums.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("ERROR @%0t: unexpected result %0d last=%b", $time,
                   $signed(got_val), got_last);
        return;
      end
      want = pending_sums.pop_front();
      if (want.value !== got_val || want.last !== got_last) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("ERROR @%0t: expected %0d last=%b, got %0d last=%b", $time,
                   $signed(want.value), want.last, $signed(got_val), got_last);
      end
    endfunction

    function void close_out();
      if (pending_sums.size() != 0) begin
        fail_count += pending_sums.size();
        $display("ERROR: %0d filtered values never arrived", pending_sums.size());
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [PIX_IN_W-1:0]         in_pixel_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [OUT_W-1:0]     out_filtered_value;
  logic                        out_frame_last;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [MASK_W-1:0]           cfg_data = '0;

  conv_window_checker board;
  int gap_pct     = 0;    // chance (%) of an idle gap after a pixel beat
  int stall_pct   = 0;    // chance (%) of the sink starting a stall
  int hold_left   = 0;
  int pixels_in   = 0;
  int cycle_count = 0;

  conv3x3_image_filter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_value (out_filtered_value),
    .out_frame_last     (out_frame_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("conv3x3_image_filter verification failed");
      $finish;
    end
  end

  // Mostly short idle spells. Now and then a long one.
  function automatic int pick_gap(int pct);
    int p;
    p = $urandom_range(99);
    if (p >= pct) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(30, 10);
    return $urandom_range(3, 1);
  endfunction

  // Result side: take the beat seen at this edge, then choose the next stall.
  // out_stall is read here before its nonblocking update, so the check sees
  // the value that the block saw at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_sum(out_filtered_value, out_frame_last);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      hold_left = pick_gap(stall_pct);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [MASK_W-1:0] mask_of(logic [SLOT_W-1:0] c0, logic [SLOT_W-1:0] c1,
                                                logic [SLOT_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [SLOT_W-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return SLOT_W'($urandom_range(8) - 4);
      default: return SLOT_W'($urandom);
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask_row();
    if ($urandom_range(7) == 0) return MASK_W'({$urandom, $urandom});
    return mask_of(rand_coef(), rand_coef(), rand_coef());
  endfunction

  // Size word: only the low DIM_W bits matter. Junk above them half the time.
  function automatic logic [MASK_W-1:0] dim_word(int v);
    logic [MASK_W-1:0] d;
    d = $urandom_range(1) ? MASK_W'({$urandom, $urandom}) : '0;
    d[DIM_W-1:0] = v[DIM_W-1:0];
    return d;
  endfunction

  function automatic int rand_width();
    int p;
    p = $urandom_range(99);
    if (p < 10) return $urandom_range(2);      // acts as the minimum
    if (p < 20) return $urandom_range(40, 13);
    return $urandom_range(12, KSIZE);
  endfunction

  function automatic int rand_height();
    if ($urandom_range(9) == 0) return $urandom_range(2);
    return $urandom_range(8, KSIZE);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // Register writes in a rotated order. Either every register or a random
  // subset is written. Sometimes a write to a spare index is added as well.
  task automatic load_setup(input logic [MASK_W-1:0] wdata, input logic [MASK_W-1:0] hdata,
                            input logic [MASK_W-1:0] m0, input logic [MASK_W-1:0] m1,
                            input logic [MASK_W-1:0] m2, input bit all_regs);
    logic [MASK_W-1:0] vals [NUM_REGS];
    int                off;
    int                k;
    vals[REG_IMAGE_WIDTH]  = wdata;
    vals[REG_IMAGE_HEIGHT] = hdata;
    vals[REG_MASK_TOP]     = m0;
    vals[REG_MASK_MIDDLE]  = m1;
    vals[REG_MASK_BOTTOM]  = m2;
    off = $urandom_range(NUM_REGS - 1);
    for (int j = 0; j < NUM_REGS; j++) begin
      k = (j + off) % NUM_REGS;
      if (all_regs || $urandom_range(1) == 1) write_reg(CFG_IDX_W'(k), vals[k]);
    end
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_HI, SPARE_IDX_LO)),
                MASK_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  // Let the pipeline run dry. Config may be touched only after this.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One pixel beat. in_valid is dropped only when a gap follows. Back-to-back
  // beats keep it high, so it never gets two updates in one step.
  task automatic send_pixel(input logic [PIX_IN_W-1:0] pix, input int gap);
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_pixel(pix);
    pixels_in++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One whole frame at the current size. If pause_at >= 0, the sender halts
  // before that pixel until every pending result has come out.
  task automatic send_frame(input pixel_style_t style, input int pause_at);
    int                  total;
    logic [PIX_IN_W-1:0] pix;
    total = board.eff_width() * board.eff_height();
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) settle();
      case (style)
        PIX_FULL:    pix = '1;
        PIX_CHECKER: pix = i[0] ? '1 : '0;
        PIX_RAILS:   pix = $urandom_range(1) ? '1 : '0;
        PIX_DIM:     pix = PIX_IN_W'($urandom_range(3));
        default:     pix = PIX_IN_W'($urandom_range(255));
      endcase
      send_pixel(pix, pick_gap(gap_pct));
    end
  endtask

  function automatic pixel_style_t rand_style();
    case ($urandom_range(9))
      0:       return PIX_RAILS;
      1:       return PIX_DIM;
      default: return PIX_RANDOM;
    endcase
  endfunction

  initial begin
    int  random_goal;
    int  pause_at;
    bit  paused;
    board  = new();
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the smallest size. Width 0 and height 2 both act as 3.
    // All nine taps are the most negative coefficient and every pixel is full
    // scale, which gives the most negative sum.
    load_setup(dim_word(0), dim_word(2), mask_of(COEF_MIN, COEF_MIN, COEF_MIN),
               mask_of(COEF_MIN, COEF_MIN, COEF_MIN), mask_of(COEF_MIN, COEF_MIN, COEF_MIN), 1'b1);
    for (int i = SPARE_IDX_LO; i <= SPARE_IDX_HI; i++)
      write_reg(CFG_IDX_W'(i), MASK_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    send_frame(PIX_FULL, -1);
    settle();

    // Largest positive sum. Then width 1 (acts as 3) with a checker pattern
    // under a random mask, with both sides idling.
    write_reg(REG_MASK_TOP, mask_of(COEF_MAX, COEF_MAX, COEF_MAX));
    write_reg(REG_MASK_MIDDLE, mask_of(COEF_MAX, COEF_MAX, COEF_MAX));
    write_reg(REG_MASK_BOTTOM, mask_of(COEF_MAX, COEF_MAX, COEF_MAX));
    cfg_valid <= 1'b0;
    send_frame(PIX_FULL, -1);
    settle();
    gap_pct   = 50;
    stall_pct = 50;
    load_setup(dim_word(1), dim_word(KSIZE), rand_mask_row(), rand_mask_row(),
               rand_mask_row(), 1'b1);
    send_frame(PIX_CHECKER, -1);

    // Random phases. Each phase has fresh sizes, mask and idling, then streams
    // one to three frames back to back so that the counter wrap is exercised.
    random_goal = pixels_in + RANDOM_PIXELS;
    while (pixels_in < random_goal) begin
      settle();
      gap_pct   = 25 * $urandom_range(2);
      stall_pct = 25 * $urandom_range(2);
      load_setup(dim_word(rand_width()), dim_word(rand_height()), rand_mask_row(),
                 rand_mask_row(), rand_mask_row(), $urandom_range(1) == 1);
      repeat ($urandom_range(3, 1)) begin
        if (pixels_in >= random_goal) break;
        pause_at = -1;
        if (!paused && pixels_in > random_goal - RANDOM_PIXELS / 2) begin
          pause_at = board.eff_width() * board.eff_height() / 2;
          paused   = 1'b1;
        end
        send_frame(rand_style(), pause_at);
      end
    end

    settle();
    board.close_out();
    if (board.fail_count == 0) begin
      $display("conv3x3_image_filter verification clean");
    end else begin
      $display("conv3x3_image_filter verification failed");
    end
    $finish;
  end

endmodule
